### rtl/core/gtpie_pkg.sv
package gtpie_pkg;

	localparam int NREC   = 6;
	localparam int RW     = 3;
	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	localparam logic [4:0] F_CAUSE   = 5'd1;
	localparam logic [4:0] F_IMSI    = 5'd2;
	localparam logic [4:0] F_IMEI    = 5'd3;
	localparam logic [4:0] F_MSISDN  = 5'd4;
	localparam logic [4:0] F_MCC     = 5'd5;
	localparam logic [4:0] F_MNC     = 5'd6;
	localparam logic [4:0] F_LAC     = 5'd7;
	localparam logic [4:0] F_RAC     = 5'd8;
	localparam logic [4:0] F_CID     = 5'd9;
	localparam logic [4:0] F_SAC     = 5'd10;
	localparam logic [4:0] F_TEID_D  = 5'd11;
	localparam logic [4:0] F_TEID_C  = 5'd12;
	localparam logic [4:0] F_NSAPI   = 5'd13;
	localparam logic [4:0] F_UE_ADDR = 5'd14;
	localparam logic [4:0] F_GSN1    = 5'd15;
	localparam logic [4:0] F_GSN2    = 5'd16;
	localparam logic [4:0] F_APN     = 5'd17;
	localparam logic [4:0] F_ARP     = 5'd18;
	localparam logic [4:0] F_DELAY   = 5'd19;
	localparam logic [4:0] F_RELIAB  = 5'd20;
	localparam logic [4:0] F_PREC    = 5'd21;
	localparam logic [4:0] F_TCLASS  = 5'd22;
	localparam logic [4:0] F_SDU     = 5'd23;
	localparam logic [4:0] F_MAX_UL  = 5'd24;
	localparam logic [4:0] F_MAX_DL  = 5'd25;
	localparam logic [4:0] F_THP     = 5'd26;
	localparam logic [4:0] F_GBR_UL  = 5'd27;
	localparam logic [4:0] F_GBR_DL  = 5'd28;
	localparam logic [4:0] F_RAT     = 5'd29;
	localparam logic [4:0] F_DTFLAG  = 5'd30;
	localparam logic [4:0] F_UNKNOWN = 5'd31;

	localparam logic [7:0] IE_CAUSE    = 8'd1;
	localparam logic [7:0] IE_IMSI     = 8'd2;
	localparam logic [7:0] IE_RAI      = 8'd3;
	localparam logic [7:0] IE_TEID_D   = 8'd16;
	localparam logic [7:0] IE_TEID_C   = 8'd17;
	localparam logic [7:0] IE_NSAPI    = 8'd20;
	localparam logic [7:0] IE_UE_ADDR  = 8'd128;
	localparam logic [7:0] IE_APN      = 8'd131;
	localparam logic [7:0] IE_GSN_ADDR = 8'd133;
	localparam logic [7:0] IE_MSISDN   = 8'd134;
	localparam logic [7:0] IE_QOS      = 8'd135;
	localparam logic [7:0] IE_RAT      = 8'd151;
	localparam logic [7:0] IE_ULI      = 8'd152;
	localparam logic [7:0] IE_IMEI     = 8'd154;
	localparam logic [7:0] IE_COMMON   = 8'd182;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [4:0]  field_code;
		logic [15:0] field_index;
		logic [31:0] field_value;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [4:0]  code;
		logic [15:0] index;
		logic [31:0] value;
		logic        is_rate;
	} rec_t;

	typedef struct packed {
		rec_t [NREC-1:0] recs;
		logic [RW-1:0]   cnt;
	} bundle_t;

	function automatic logic [7:0] tbcd(input logic [3:0] nib);
		logic [7:0] c;
		case (nib)
			4'ha:    c = 8'h2a;
			4'hb:    c = 8'h23;
			4'hc:    c = 8'h61;
			4'hd:    c = 8'h62;
			4'he:    c = 8'h63;
			4'hf:    c = 8'h00;
			default: c = 8'h30 + {4'd0, nib};
		endcase
		return c;
	endfunction

	function automatic logic [3:0] tv_total(input logic [7:0] t);
		logic [3:0] r;
		case (t)
			8'd1, 8'd8, 8'd14, 8'd15, 8'd19, 8'd20: r = 4'd2;
			8'd2:                                   r = 4'd9;
			8'd3:                                   r = 4'd7;
			8'd16, 8'd17, 8'd127:                   r = 4'd5;
			8'd26:                                  r = 4'd3;
			default:                                r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic tlv_known(input logic [7:0] t);
		logic r;
		case (t)
			8'd128, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd137,
			8'd148, 8'd151, 8'd152, 8'd153, 8'd154, 8'd182, 8'd191,
			8'd251, 8'd255: r = 1'b1;
			default:        r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] max_rate(input logic [7:0] i);
		logic [13:0] m;
		if (i == 8'h00 || i == 8'hff) begin
			m = 14'd0;
		end else if (i <= 8'h3f) begin
			m = {6'd0, i};
		end else if (i <= 8'h7f) begin
			m = 14'({i, 3'b000}) - 14'd448;
		end else begin
			m = {i, 6'b000000} - 14'd7616;
		end
		return {18'd0, m} * 32'd1000;
	endfunction

	function automatic logic [31:0] ext_rate(input logic [7:0] i);
		logic [31:0] r;
		if (i == 8'h00 || i == 8'hff) begin
			r = 32'd0;
		end else if (i <= 8'h4a) begin
			r = 32'd8600000 + {24'd0, i} * 32'd100000;
		end else if (i <= 8'hba) begin
			r = 32'd16000000 + {24'd0, i - 8'h4a} * 32'd1000000;
		end else begin
			r = 32'd128000000 + {24'd0, i - 8'hba} * 32'd2000000;
		end
		return r;
	endfunction

endpackage

### rtl/core/gtp_ie_stream_parser.sv
// GTPv1-C information-element parser.
// Input channel: one word per cycle, a byte of the IE area plus an end-of-message
// flag, taken when push is high and full is low.
// Result channel: tagged field records (code, index, value, last_of_run), shown
// while empty is low and taken when pop is high.
// The front end decodes each byte in the cycle it is taken and writes the 0 to 6
// records it causes as one group into a two-deep group queue. The back end pulls
// one record per cycle from the queue head while the output register is free or
// popped, decodes QoS rates, and registers it; a record passes through the
// group queue and the output register. Throughput: one byte per cycle while each
// byte yields at most one record and pop stays high; a byte with more records
// holds the result port until all are shown, and the group queue hides short bursts.
// When pop stays low the output register holds, the queue fills and full rises;
// nothing is dropped.
// Reset clears the parser state, the queue and the output register. The end of
// message flag returns the parser to its reset state after that byte.
module gtp_ie_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  gtpie_pkg::item_t    item,
	input  logic                pop,
	output logic                empty,
	output gtpie_pkg::result_t  result
);

	logic               take;
	logic               q_wr;
	logic               q_rd;
	logic               q_valid;
	gtpie_pkg::bundle_t bundle;
	gtpie_pkg::bundle_t head;

	assign take = push && !full;
	assign q_wr = take && (bundle.cnt != '0);

	gtpie_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.bundle (bundle)
	);

	gtpie_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (bundle),
		.rd     (q_rd),
		.rdata  (head),
		.valid  (q_valid),
		.full   (full)
	);

	gtpie_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_no_fill_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |=> !$fell(empty))
		else $error("result appeared with no group queued");
	a_full_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_valid)
		else $error("group queue full but reports no head");
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.field_code != 5'd0)
		else $error("result record with empty field code");
	a_read_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_valid && head.cnt != '0)
		else $error("group queue read while empty");
`endif

endmodule

### rtl/core/gtpie_front.sv
module gtpie_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  gtpie_pkg::item_t    item,
	output gtpie_pkg::bundle_t  bundle
);

	localparam logic [15:0] BASE_OFF [4] = '{16'd9, 16'd10, 16'd13, 16'd14};
	localparam logic [15:0] EXT_OFF  [4] = '{16'd18, 16'd16, 16'd19, 16'd17};
	localparam logic [2:0]  EXT_SLOT [4] = '{3'd6, 3'd4, 3'd7, 3'd5};
	localparam logic [4:0]  RATE_CODE [4] = '{gtpie_pkg::F_MAX_UL, gtpie_pkg::F_MAX_DL,
		gtpie_pkg::F_GBR_UL, gtpie_pkg::F_GBR_DL};

	logic [7:0]  kind_q, kind_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] len_q, len_n;
	logic [31:0] gather_q, gather_n;
	logic [7:0]  label_q, label_n;
	logic        first_q, first_n;
	logic        skip_q, skip_n;
	logic [7:0]  qos_q [8];
	logic [7:0]  qn [8];
	logic        qwe;
	logic [2:0]  qwa;
	gtpie_pkg::rec_t [gtpie_pkg::NREC-1:0] recs;
	logic [gtpie_pkg::RW-1:0] n;

	always_comb begin
		logic [7:0]  b;
		logic [15:0] o;
		logic        done;
		logic [3:0]  ft;
		logic [7:0]  t;
		logic        do_plmn;
		logic [1:0]  k;
		logic        do_dig;
		logic [4:0]  dcode;
		logic [15:0] didx;
		logic [15:0] sdu;
		logic [7:0]  base;
		logic [7:0]  ext;
		logic        use_ext;
		b        = item.data_byte;
		o        = pos_q;
		done     = 1'b0;
		ft       = gtpie_pkg::tv_total(b);
		t        = gather_q[31:24];
		do_plmn  = 1'b0;
		k        = 2'd0;
		do_dig   = 1'b0;
		dcode    = gtpie_pkg::F_IMSI;
		didx     = 16'd0;
		sdu      = ({8'd0, b} << 3) + ({8'd0, b} << 1);
		kind_n   = kind_q;
		pos_n    = pos_q;
		len_n    = len_q;
		gather_n = gather_q;
		label_n  = label_q;
		first_n  = first_q;
		skip_n   = skip_q;
		qwe      = 1'b0;
		qwa      = 3'd0;
		recs     = '0;
		n        = '0;
		for (int i = 0; i < 8; i++) begin
			qn[i] = qos_q[i];
		end
		if (!skip_q) begin
			if (kind_q == 8'd0) begin
				if (ft == 4'd0 && !gtpie_pkg::tlv_known(b)) begin
					recs[n] = '{gtpie_pkg::F_UNKNOWN, 16'd0, {24'd0, b}, 1'b0};
					n = n + 3'd1;
					skip_n = 1'b1;
				end else begin
					kind_n   = b;
					pos_n    = 16'd1;
					len_n    = (ft != 4'd0) ? {12'd0, ft - 4'd1} : 16'd0;
					gather_n = 32'd0;
					label_n  = 8'd0;
				end
			end else begin
				if (kind_q >= 8'd128 && o <= 16'd2) begin
					if (o == 16'd1) begin
						len_n = {8'd0, b};
						done  = 1'b0;
					end else begin
						len_n = {len_q[7:0], b};
						done  = (len_n == 16'd0);
					end
				end else begin
					case (kind_q)
						gtpie_pkg::IE_CAUSE: begin
							if (o == 16'd1) begin
								recs[n] = '{gtpie_pkg::F_CAUSE, 16'd0, {24'd0, b}, 1'b0};
								n = n + 3'd1;
							end
						end
						gtpie_pkg::IE_IMSI: begin
							if (o <= 16'd8) begin
								do_dig = 1'b1;
								dcode  = gtpie_pkg::F_IMSI;
								didx   = (o - 16'd1) << 1;
							end
						end
						gtpie_pkg::IE_RAI: begin
							if (o <= 16'd3) begin
								do_plmn = 1'b1;
								k       = o[1:0] - 2'd1;
							end else if (o == 16'd4) begin
								gather_n = {gather_q[31:16], gather_q[7:0], b};
							end else if (o == 16'd5) begin
								gather_n = {gather_q[31:16], gather_q[7:0], b};
								if (gather_n[15:0] != 16'd65534 && gather_n[15:0] != 16'd0) begin
									recs[n] = '{gtpie_pkg::F_LAC, 16'd0, {16'd0, gather_n[15:0]}, 1'b0};
									n = n + 3'd1;
								end
							end else if (b != 8'hff) begin
								recs[n] = '{gtpie_pkg::F_RAC, 16'd0, {24'd0, b}, 1'b0};
								n = n + 3'd1;
							end
						end
						gtpie_pkg::IE_TEID_D, gtpie_pkg::IE_TEID_C: begin
							gather_n = {gather_q[23:0], b};
							if (o == 16'd4) begin
								recs[n] = '{(kind_q == gtpie_pkg::IE_TEID_D) ? gtpie_pkg::F_TEID_D
									: gtpie_pkg::F_TEID_C, 16'd0, gather_n, 1'b0};
								n = n + 3'd1;
							end
						end
						gtpie_pkg::IE_NSAPI: begin
							if (o == 16'd1) begin
								recs[n] = '{gtpie_pkg::F_NSAPI, 16'd0, {24'd0, b}, 1'b0};
								n = n + 3'd1;
							end
						end
						gtpie_pkg::IE_UE_ADDR: begin
							if (o >= 16'd5 && o <= 16'd8) begin
								gather_n = {gather_q[23:0], b};
								if (o == 16'd8 && len_q == 16'd1) begin
									recs[n] = '{gtpie_pkg::F_UE_ADDR, 16'd0, gather_n, 1'b0};
									n = n + 3'd1;
								end
							end
						end
						gtpie_pkg::IE_APN: begin
							if (label_q == 8'd0) begin
								// length byte: a dot goes between labels
								if (o > 16'd3) begin
									recs[n] = '{gtpie_pkg::F_APN, gather_q[15:0], 32'h2e, 1'b0};
									n = n + 3'd1;
									gather_n = gather_q + 32'd1;
								end
								label_n = b;
							end else begin
								recs[n] = '{gtpie_pkg::F_APN, gather_q[15:0], {24'd0, b}, 1'b0};
								n = n + 3'd1;
								gather_n = gather_q + 32'd1;
								label_n  = label_q - 8'd1;
							end
						end
						gtpie_pkg::IE_GSN_ADDR: begin
							if (o >= 16'd3 && o <= 16'd6) begin
								gather_n = {gather_q[23:0], b};
								if (o == 16'd6) begin
									recs[n] = '{first_q ? gtpie_pkg::F_GSN2 : gtpie_pkg::F_GSN1,
										16'd0, gather_n, 1'b0};
									n = n + 3'd1;
									first_n = 1'b1;
								end
							end
						end
						gtpie_pkg::IE_MSISDN: begin
							if (o >= 16'd4) begin
								do_dig = 1'b1;
								dcode  = gtpie_pkg::F_MSISDN;
								didx   = (o - 16'd4) << 1;
							end
						end
						gtpie_pkg::IE_QOS: begin
							case (o)
								16'd3: begin
									recs[n] = '{gtpie_pkg::F_ARP, 16'd0, {24'd0, b}, 1'b0};
									n = n + 3'd1;
								end
								16'd4: begin
									recs[n] = '{gtpie_pkg::F_DELAY, 16'd0, {27'd0, b[7:3]}, 1'b0};
									n = n + 3'd1;
									recs[n] = '{gtpie_pkg::F_RELIAB, 16'd0, {29'd0, b[2:0]}, 1'b0};
									n = n + 3'd1;
								end
								16'd5: begin
									recs[n] = '{gtpie_pkg::F_PREC, 16'd0, {29'd0, b[2:0]}, 1'b0};
									n = n + 3'd1;
								end
								16'd7: begin
									recs[n] = '{gtpie_pkg::F_TCLASS, 16'd0, {29'd0, b[7:5]}, 1'b0};
									n = n + 3'd1;
								end
								16'd8: begin
									recs[n] = '{gtpie_pkg::F_SDU, 16'd0, {16'd0, sdu}, 1'b0};
									n = n + 3'd1;
								end
								16'd9:  begin qwe = 1'b1; qwa = 3'd0; end
								16'd10: begin qwe = 1'b1; qwa = 3'd1; end
								16'd12: begin
									recs[n] = '{gtpie_pkg::F_THP, 16'd0, {29'd0, b[2:0]}, 1'b0};
									n = n + 3'd1;
								end
								16'd13: begin qwe = 1'b1; qwa = 3'd2; end
								16'd14: begin qwe = 1'b1; qwa = 3'd3; end
								16'd16: begin qwe = 1'b1; qwa = 3'd4; end
								16'd17: begin qwe = 1'b1; qwa = 3'd5; end
								16'd18: begin qwe = 1'b1; qwa = 3'd6; end
								16'd19: begin qwe = 1'b1; qwa = 3'd7; end
								default: ;
							endcase
						end
						gtpie_pkg::IE_RAT: begin
							if (o == 16'd3) begin
								recs[n] = '{gtpie_pkg::F_RAT, 16'd0, {24'd0, b}, 1'b0};
								n = n + 3'd1;
							end
						end
						gtpie_pkg::IE_ULI: begin
							if (o == 16'd3) begin
								gather_n = {b, 24'd0};
							end else if (o <= 16'd6) begin
								do_plmn = 1'b1;
								k       = o[1:0];
							end else if (o <= 16'd10) begin
								gather_n = {gather_q[31:16], gather_q[7:0], b};
								if (o == 16'd8 && t <= 8'd2) begin
									recs[n] = '{gtpie_pkg::F_LAC, 16'd0, {16'd0, gather_n[15:0]}, 1'b0};
									n = n + 3'd1;
								end
								if (o == 16'd10 && t <= 8'd2) begin
									recs[n] = '{(t == 8'd0) ? gtpie_pkg::F_CID
										: ((t == 8'd1) ? gtpie_pkg::F_SAC : gtpie_pkg::F_RAC),
										16'd0, {16'd0, gather_n[15:0]}, 1'b0};
									n = n + 3'd1;
								end
							end
						end
						gtpie_pkg::IE_IMEI: begin
							if (o >= 16'd3 && o <= 16'd10) begin
								do_dig = 1'b1;
								dcode  = gtpie_pkg::F_IMEI;
								didx   = (o - 16'd3) << 1;
							end
						end
						gtpie_pkg::IE_COMMON: begin
							if (o == 16'd3 && b[0]) begin
								recs[n] = '{gtpie_pkg::F_DTFLAG, 16'd0, 32'd1, 1'b0};
								n = n + 3'd1;
							end
						end
						default: ;
					endcase
					if (do_plmn) begin
						case (k)
							2'd0: begin
								do_dig = 1'b1;
								dcode  = gtpie_pkg::F_MCC;
								didx   = 16'd0;
							end
							2'd1: begin
								recs[n] = '{gtpie_pkg::F_MCC, 16'd2,
									{24'd0, gtpie_pkg::tbcd(b[3:0])}, 1'b0};
								n = n + 3'd1;
								// hold MNC digit 3 until the last PLMN byte
								gather_n[19:16] = b[7:4];
							end
							default: begin
								recs[n] = '{gtpie_pkg::F_MNC, 16'd0,
									{24'd0, gtpie_pkg::tbcd(b[3:0])}, 1'b0};
								n = n + 3'd1;
								recs[n] = '{gtpie_pkg::F_MNC, 16'd1,
									{24'd0, gtpie_pkg::tbcd(b[7:4])}, 1'b0};
								n = n + 3'd1;
								recs[n] = '{gtpie_pkg::F_MNC, 16'd2,
									{24'd0, gtpie_pkg::tbcd(gather_q[19:16])}, 1'b0};
								n = n + 3'd1;
							end
						endcase
					end
					if (do_dig) begin
						recs[n] = '{dcode, didx, {24'd0, gtpie_pkg::tbcd(b[3:0])}, 1'b0};
						n = n + 3'd1;
						recs[n] = '{dcode, didx + 16'd1, {24'd0, gtpie_pkg::tbcd(b[7:4])}, 1'b0};
						n = n + 3'd1;
					end
					len_n = len_q - 16'd1;
					done  = (len_n == 16'd0);
				end
				if (qwe) begin
					qn[qwa] = b;
				end
				if (done) begin
					if (kind_q == gtpie_pkg::IE_QOS) begin
						// rates go out raw; the back end decodes them
						for (int j = 0; j < 4; j++) begin
							if (BASE_OFF[j] <= o) begin
								base    = qn[j];
								ext     = qn[EXT_SLOT[j]];
								use_ext = (base == 8'hfe) && (EXT_OFF[j] <= o) && (ext != 8'd0);
								recs[n] = '{RATE_CODE[j], 16'd0, {15'd0, use_ext, ext, base}, 1'b1};
								n = n + 3'd1;
							end
						end
					end
					kind_n = 8'd0;
					pos_n  = 16'd0;
				end else begin
					pos_n = (o != 16'hffff) ? o + 16'd1 : o;
				end
			end
		end
		if (item.end_of_message) begin
			kind_n   = 8'd0;
			pos_n    = 16'd0;
			len_n    = 16'd0;
			gather_n = 32'd0;
			label_n  = 8'd0;
			first_n  = 1'b0;
			skip_n   = 1'b0;
		end
	end

	assign bundle.recs = recs;
	assign bundle.cnt  = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= 8'd0;
			pos_q    <= 16'd0;
			len_q    <= 16'd0;
			gather_q <= 32'd0;
			label_q  <= 8'd0;
			first_q  <= 1'b0;
			skip_q   <= 1'b0;
		end else if (take) begin
			kind_q   <= kind_n;
			pos_q    <= pos_n;
			len_q    <= len_n;
			gather_q <= gather_n;
			label_q  <= label_n;
			first_q  <= first_n;
			skip_q   <= skip_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && qwe) begin
			qos_q[qwa] <= item.data_byte;
		end
	end

endmodule

### rtl/core/gtpie_queue.sv
module gtpie_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  gtpie_pkg::bundle_t wdata,
	input  logic               rd,
	output gtpie_pkg::bundle_t rdata,
	output logic               valid,
	output logic               full
);

	gtpie_pkg::bundle_t mem_q [gtpie_pkg::QDEPTH];
	logic [gtpie_pkg::QAW-1:0] wp_q, rp_q;
	logic [gtpie_pkg::QCW-1:0] cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == gtpie_pkg::QCW'(gtpie_pkg::QDEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

### rtl/core/gtpie_back.sv
module gtpie_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  gtpie_pkg::bundle_t head,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output gtpie_pkg::result_t result
);

	logic [gtpie_pkg::RW-1:0] r_q;
	logic                     ovalid_q;
	gtpie_pkg::result_t       out_q;
	gtpie_pkg::rec_t          cur;
	logic                     load;
	logic                     last;
	logic [31:0]              value;

	assign cur  = head.recs[r_q];
	assign load = q_valid && (!ovalid_q || pop);
	assign last = (r_q == head.cnt - 3'd1);
	assign q_rd = load && last;

	always_comb begin
		value = cur.value;
		if (cur.is_rate) begin
			value = cur.value[16] ? gtpie_pkg::ext_rate(cur.value[15:8])
				: gtpie_pkg::max_rate(cur.value[7:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				r_q      <= last ? '0 : r_q + 3'd1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= '{cur.code, cur.index, value, last};
		end
	end

	assign empty  = !ovalid_q;
	assign result = out_q;

endmodule

### verif/gtp_ie_stream_parser_tb.sv
module gtp_ie_stream_parser_tb;

	localparam int LIMIT = 400000;

	// IE types decoded only as fixed-size skips; then an unknown type, no IE and the rate escape
	localparam logic [7:0] IE_REORDER  = 8'd8;
	localparam logic [7:0] IE_RECOVERY = 8'd14;
	localparam logic [7:0] IE_SELMODE  = 8'd15;
	localparam logic [7:0] IE_TEARDOWN = 8'd19;
	localparam logic [7:0] IE_CHGCHAR  = 8'd26;
	localparam logic [7:0] IE_CHGID    = 8'd127;
	localparam logic [7:0] IE_UNKNOWN4 = 8'd4;
	localparam logic [7:0] IE_NONE     = 8'd0;
	localparam logic [7:0] RATE_EXT    = 8'hfe;

	typedef struct {
		logic [7:0]  b;
		bit          eom;
		bit          typed;
		logic [4:0]  code;
		logic [15:0] idx;
		logic [31:0] val;
	} row_t;

	logic               clk, arst_n, push, full, pop, empty;
	gtpie_pkg::item_t   item;
	gtpie_pkg::result_t result;

	gtp_ie_stream_parser uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result)
	);

	// parser shadow state
	logic [7:0]  ie_type;
	logic [15:0] ie_pos, ie_left;
	logic [31:0] gath;
	logic [7:0]  label_left;
	logic [7:0]  rate_bytes [8];
	bit          gsn_seen, skipping;

	gtpie_pkg::result_t records [$];
	gtpie_pkg::result_t expected_records [$];
	row_t    typed_rows [$];
	int      cyc = 0;
	bit      failed = 0;
	bit      quiet;

	assign quiet = cyc >= 150 && cyc < 350;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] tbcd_char(input logic [3:0] n);
		string s;
		s = "0123456789*#abc";
		return n == 4'hf ? 8'h00 : s[n];
	endfunction

	function automatic logic [7:0] fixed_size(input logic [7:0] t);
		case (t)
			gtpie_pkg::IE_CAUSE, IE_REORDER, IE_RECOVERY, IE_SELMODE, IE_TEARDOWN,
			gtpie_pkg::IE_NSAPI:                             return 2;
			gtpie_pkg::IE_IMSI:                              return 9;
			gtpie_pkg::IE_RAI:                               return 7;
			gtpie_pkg::IE_TEID_D, gtpie_pkg::IE_TEID_C, IE_CHGID: return 5;
			IE_CHGCHAR:                                      return 3;
			default:                                         return 0;
		endcase
	endfunction

	function automatic bit tlv_type(input logic [7:0] t);
		return t inside {8'd128, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd137, 8'd148,
			8'd151, 8'd152, 8'd153, 8'd154, 8'd182, 8'd191, 8'd251, 8'd255};
	endfunction

	function automatic logic [31:0] base_rate(input logic [7:0] i);
		if (i == 0 || i == 8'hff) return 0;
		if (i <= 8'h3f) return i * 1000;
		if (i <= 8'h7f) return (64 + 8 * (i - 8'h40)) * 1000;
		return (576 + 64 * (i - 8'h80)) * 1000;
	endfunction

	function automatic logic [31:0] extended_rate(input logic [7:0] i);
		if (i == 0 || i == 8'hff) return 0;
		if (i <= 8'h4a) return 8600000 + i * 100000;
		if (i <= 8'hba) return 16000000 + (i - 8'h4a) * 1000000;
		return 128000000 + (i - 8'hba) * 2000000;
	endfunction

	function automatic void add_record(input logic [4:0] c, input logic [15:0] i,
			input logic [31:0] v);
		if (records.size() < gtpie_pkg::NREC) records.push_back('{c, i, v, 1'b0});
	endfunction

	function automatic void add_digits(input logic [4:0] c, input logic [15:0] i,
			input logic [7:0] b);
		add_record(c, i, tbcd_char(b[3:0]));
		add_record(c, i + 16'd1, tbcd_char(b[7:4]));
	endfunction

	function automatic void add_plmn(input logic [15:0] k, input logic [7:0] b);
		if (k == 0) begin
			add_digits(gtpie_pkg::F_MCC, 0, b);
		end else if (k == 1) begin
			add_record(gtpie_pkg::F_MCC, 2, tbcd_char(b[3:0]));
			gath[19:16] = b[7:4];
		end else begin
			add_digits(gtpie_pkg::F_MNC, 0, b);
			add_record(gtpie_pkg::F_MNC, 2, tbcd_char(gath[19:16]));
		end
	endfunction

	function automatic void shift16(input logic [7:0] b);
		gath[15:0] = {gath[7:0], b};
	endfunction

	function automatic void qos_octet(input logic [15:0] o, input logic [7:0] b);
		case (o)
			3: add_record(gtpie_pkg::F_ARP, 0, b);
			4: begin
				add_record(gtpie_pkg::F_DELAY, 0, b[7:3]);
				add_record(gtpie_pkg::F_RELIAB, 0, b[2:0]);
			end
			5: add_record(gtpie_pkg::F_PREC, 0, b[2:0]);
			7: add_record(gtpie_pkg::F_TCLASS, 0, b[7:5]);
			8: add_record(gtpie_pkg::F_SDU, 0, b * 10);
			9: rate_bytes[0] = b;
			10: rate_bytes[1] = b;
			12: add_record(gtpie_pkg::F_THP, 0, b[2:0]);
			13: rate_bytes[2] = b;
			14: rate_bytes[3] = b;
			16, 17, 18, 19: rate_bytes[o - 12] = b;
			default: ;
		endcase
	endfunction

	function automatic void qos_rates(input logic [15:0] last);
		int base_at [4] = '{9, 10, 13, 14};
		int ext_at [4] = '{18, 16, 19, 17};
		logic [4:0] which [4] = '{gtpie_pkg::F_MAX_UL, gtpie_pkg::F_MAX_DL,
			gtpie_pkg::F_GBR_UL, gtpie_pkg::F_GBR_DL};
		logic [31:0] r;
		for (int j = 0; j < 4; j++) begin
			if (base_at[j] <= last) begin
				r = base_rate(rate_bytes[j]);
				if (r == 8640000 && ext_at[j] <= last && rate_bytes[ext_at[j] - 12] != 0)
					r = extended_rate(rate_bytes[ext_at[j] - 12]);
				add_record(which[j], 0, r);
			end
		end
	endfunction

	function automatic void decode_body(input logic [15:0] o, input logic [7:0] b);
		logic [7:0] t;
		case (ie_type)
			gtpie_pkg::IE_CAUSE: if (o == 1) add_record(gtpie_pkg::F_CAUSE, 0, b);
			gtpie_pkg::IE_IMSI:
				if (o <= 8) add_digits(gtpie_pkg::F_IMSI, (o - 16'd1) * 16'd2, b);
			gtpie_pkg::IE_RAI: begin
				if (o <= 3) begin
					add_plmn(o - 16'd1, b);
				end else if (o == 4) begin
					shift16(b);
				end else if (o == 5) begin
					shift16(b);
					if (gath[15:0] != 16'd65534 && gath[15:0] != 0)
						add_record(gtpie_pkg::F_LAC, 0, gath[15:0]);
				end else if (b != 8'hff) begin
					add_record(gtpie_pkg::F_RAC, 0, b);
				end
			end
			gtpie_pkg::IE_TEID_D, gtpie_pkg::IE_TEID_C: begin
				gath = {gath[23:0], b};
				if (o == 4) add_record(ie_type == gtpie_pkg::IE_TEID_D ? gtpie_pkg::F_TEID_D
					: gtpie_pkg::F_TEID_C, 0, gath);
			end
			gtpie_pkg::IE_NSAPI: if (o == 1) add_record(gtpie_pkg::F_NSAPI, 0, b);
			gtpie_pkg::IE_UE_ADDR: if (o >= 5 && o <= 8) begin
				gath = {gath[23:0], b};
				if (o == 8 && ie_left == 1) add_record(gtpie_pkg::F_UE_ADDR, 0, gath);
			end
			gtpie_pkg::IE_APN: begin
				if (label_left == 0) begin
					if (o > 3) begin
						add_record(gtpie_pkg::F_APN, gath[15:0], ".");
						gath++;
					end
					label_left = b;
				end else begin
					add_record(gtpie_pkg::F_APN, gath[15:0], b);
					gath++;
					label_left--;
				end
			end
			gtpie_pkg::IE_GSN_ADDR: if (o >= 3 && o <= 6) begin
				gath = {gath[23:0], b};
				if (o == 6) begin
					add_record(gsn_seen ? gtpie_pkg::F_GSN2 : gtpie_pkg::F_GSN1, 0, gath);
					gsn_seen = 1;
				end
			end
			gtpie_pkg::IE_MSISDN:
				if (o >= 4) add_digits(gtpie_pkg::F_MSISDN, (o - 16'd4) * 16'd2, b);
			gtpie_pkg::IE_QOS: qos_octet(o, b);
			gtpie_pkg::IE_RAT: if (o == 3) add_record(gtpie_pkg::F_RAT, 0, b);
			gtpie_pkg::IE_ULI: begin
				t = gath[31:24];
				if (o == 3) begin
					gath = {b, 24'd0};
				end else if (o <= 6) begin
					add_plmn(o - 16'd4, b);
				end else if (o <= 10) begin
					shift16(b);
					if (o == 8 && t <= 2) add_record(gtpie_pkg::F_LAC, 0, gath[15:0]);
					if (o == 10 && t <= 2)
						add_record(t == 0 ? gtpie_pkg::F_CID
							: (t == 1 ? gtpie_pkg::F_SAC : gtpie_pkg::F_RAC), 0, gath[15:0]);
				end
			end
			gtpie_pkg::IE_IMEI:
				if (o >= 3 && o <= 10) add_digits(gtpie_pkg::F_IMEI, (o - 16'd3) * 16'd2, b);
			gtpie_pkg::IE_COMMON: if (o == 3 && b[0]) add_record(gtpie_pkg::F_DTFLAG, 0, 1);
			default: ;
		endcase
	endfunction

	function automatic void clear_parser();
		ie_type = IE_NONE;
		ie_pos = 0;
		ie_left = 0;
		gath = 0;
		label_left = 0;
		gsn_seen = 0;
		skipping = 0;
	endfunction

	function automatic void parse_word(input logic [7:0] b, input bit eom);
		logic [7:0] sz;
		logic [15:0] o;
		bit done;
		records.delete();
		if (skipping) begin
			// drop until end of message
		end else if (ie_type == IE_NONE) begin
			sz = fixed_size(b);
			if (sz == 0 && !tlv_type(b)) begin
				add_record(gtpie_pkg::F_UNKNOWN, 0, b);
				skipping = 1;
			end else begin
				ie_type = b;
				ie_pos = 1;
				ie_left = sz != 0 ? sz - 1 : 0;
				gath = 0;
				label_left = 0;
			end
		end else begin
			o = ie_pos;
			if (ie_type >= 128 && o <= 2) begin
				if (o == 1) begin
					ie_left = b;
					done = 0;
				end else begin
					ie_left = {ie_left[7:0], b};
					done = ie_left == 0;
				end
			end else begin
				decode_body(o, b);
				ie_left = ie_left - 16'd1;
				done = ie_left == 0;
			end
			if (done) begin
				if (ie_type == gtpie_pkg::IE_QOS) qos_rates(o);
				ie_type = IE_NONE;
				ie_pos = 0;
			end else begin
				ie_pos = o != 16'hffff ? o + 16'd1 : o;
			end
		end
		if (eom) clear_parser();
		if (records.size() > 0) records[records.size() - 1].last_of_run = 1;
	endfunction

	// predict on accepted words, check on accepted records
	always @(posedge clk) begin
		row_t r;
		gtpie_pkg::result_t e;
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && push && !full) begin
			r = typed_rows.pop_front();
			parse_word(item.data_byte, item.end_of_message);
			if (r.typed) begin
				records.delete();
				records.push_back('{r.code, r.idx, r.val, 1'b1});
			end
			foreach (records[k]) expected_records.push_back(records[k]);
		end
		if (arst_n && pop && !empty) begin
			if (expected_records.size() == 0) begin
				$error("unexpected record code=%0d index=%0d value=%0h", result.field_code,
					result.field_index, result.field_value);
				failed = 1;
			end else begin
				e = expected_records.pop_front();
				if (result.field_code !== e.field_code) begin
					$error("field_code expected %0d actual %0d", e.field_code, result.field_code);
					failed = 1;
				end
				if (result.field_index !== e.field_index) begin
					$error("field_index expected %0d actual %0d", e.field_index,
						result.field_index);
					failed = 1;
				end
				if (result.field_value !== e.field_value) begin
					$error("field_value expected %0h actual %0h", e.field_value,
						result.field_value);
					failed = 1;
				end
				if (result.last_of_run !== e.last_of_run) begin
					$error("last_of_run expected %0b actual %0b", e.last_of_run,
						result.last_of_run);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk)
		pop <= quiet || $urandom_range(99) >= 14;

	task automatic send_word(input row_t r);
		if (!quiet && $urandom_range(99) < 14) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		typed_rows.push_back(r);
		push <= 1'b1;
		item <= '{data_byte: r.b, end_of_message: r.eom};
		// full only moves at rising edges; look at it mid-cycle
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit eom);
		send_word('{b, eom, 1'b0, 5'd0, 16'd0, 32'd0});
	endtask

	function automatic logic [7:0] pick_type();
		logic [7:0] kinds [22] = '{gtpie_pkg::IE_CAUSE, gtpie_pkg::IE_IMSI,
			gtpie_pkg::IE_RAI, gtpie_pkg::IE_TEID_D, gtpie_pkg::IE_TEID_C,
			gtpie_pkg::IE_NSAPI, gtpie_pkg::IE_UE_ADDR, gtpie_pkg::IE_APN,
			gtpie_pkg::IE_GSN_ADDR, gtpie_pkg::IE_MSISDN, gtpie_pkg::IE_QOS,
			gtpie_pkg::IE_QOS, gtpie_pkg::IE_RAT, gtpie_pkg::IE_ULI, gtpie_pkg::IE_IMEI,
			gtpie_pkg::IE_COMMON, IE_REORDER, IE_RECOVERY, IE_CHGCHAR,
			IE_CHGID, gtpie_pkg::IE_GSN_ADDR, gtpie_pkg::IE_APN};
		return kinds[$urandom_range(21)];
	endfunction

	// one GTP message of back-to-back IEs, sometimes cut short or pure noise
	task automatic build_message(output logic [7:0] msg [$]);
		logic [7:0] t, body [$];
		int n, len, nl, ll;
		msg.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 8)) msg.push_back($urandom_range(255));
			return;
		end
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++) begin
			t = $urandom_range(19) == 0 ? 8'($urandom_range(255)) : pick_type();
			msg.push_back(t);
			if (!tlv_type(t)) begin
				repeat (fixed_size(t) > 0 ? fixed_size(t) - 1 : 3)
					msg.push_back($urandom_range(255));
				continue;
			end
			body.delete();
			case (t)
				gtpie_pkg::IE_APN: begin
					nl = $urandom_range(1, 3);
					for (int j = 0; j < nl; j++) begin
						ll = $urandom_range(1, 6);
						body.push_back(ll);
						repeat (ll) body.push_back($urandom_range(8'h61, 8'h7a));
					end
				end
				gtpie_pkg::IE_QOS: begin
					len = $urandom_range(3) == 0 ? $urandom_range(0, 22) : $urandom_range(14, 17);
					repeat (len) body.push_back($urandom_range(255));
					foreach (body[j])
						if ((j == 6 || j == 7 || j == 10 || j == 11) && $urandom_range(2) != 0)
							body[j] = RATE_EXT;
					foreach (body[j])
						if (j >= 13 && $urandom_range(3) == 0) body[j] = 0;
				end
				gtpie_pkg::IE_UE_ADDR: repeat ($urandom_range(1) ? 6 : $urandom_range(0, 8))
					body.push_back($urandom_range(255));
				gtpie_pkg::IE_GSN_ADDR: repeat ($urandom_range(1) ? 4 : $urandom_range(0, 16))
					body.push_back($urandom_range(255));
				gtpie_pkg::IE_ULI: begin
					body.push_back($urandom_range(0, 3));
					repeat ($urandom_range(3) != 0 ? 7 : $urandom_range(0, 9))
						body.push_back($urandom_range(255));
				end
				default: repeat ($urandom_range(0, 10)) body.push_back($urandom_range(255));
			endcase
			len = body.size();
			// claim a long IE; the message end cuts it off
			if ($urandom_range(49) == 0) begin
				len = 256 + $urandom_range(4);
			end
			msg.push_back(len >> 8);
			msg.push_back(len[7:0]);
			foreach (body[j]) msg.push_back(body[j]);
		end
		if ($urandom_range(9) == 0) msg = msg[0:$urandom_range(msg.size() - 1)];
	endtask

	row_t directed [] = '{
		'{IE_NONE, 1, 1, gtpie_pkg::F_UNKNOWN, 0, 0},
		'{gtpie_pkg::IE_CAUSE, 0, 0, 0, 0, 0},
		'{8'hff, 0, 1, gtpie_pkg::F_CAUSE, 0, 255},
		'{gtpie_pkg::IE_TEID_D, 0, 0, 0, 0, 0},
		'{8'hff, 0, 0, 0, 0, 0},
		'{8'hff, 0, 0, 0, 0, 0},
		'{8'hff, 0, 0, 0, 0, 0},
		'{8'hff, 0, 1, gtpie_pkg::F_TEID_D, 0, 32'hffffffff},
		'{gtpie_pkg::IE_NSAPI, 0, 0, 0, 0, 0},
		'{8'h00, 1, 1, gtpie_pkg::F_NSAPI, 0, 0},
		'{gtpie_pkg::IE_IMSI, 0, 0, 0, 0, 0},
		'{8'h21, 0, 0, 0, 0, 0},
		'{8'hfa, 0, 0, 0, 0, 0},
		'{8'hcb, 1, 0, 0, 0, 0},
		'{IE_UNKNOWN4, 0, 1, gtpie_pkg::F_UNKNOWN, 0, 4},
		'{8'h55, 0, 0, 0, 0, 0},
		'{8'haa, 1, 0, 0, 0, 0},
		'{gtpie_pkg::IE_RAT, 0, 0, 0, 0, 0},
		'{8'h00, 0, 0, 0, 0, 0},
		'{8'h01, 0, 0, 0, 0, 0},
		'{8'hff, 1, 1, gtpie_pkg::F_RAT, 0, 255},
		'{gtpie_pkg::IE_COMMON, 0, 0, 0, 0, 0},
		'{8'h00, 0, 0, 0, 0, 0},
		'{8'h01, 0, 0, 0, 0, 0},
		'{8'h01, 1, 1, gtpie_pkg::F_DTFLAG, 0, 1}
	};

	initial begin
		logic [7:0] msg [$];
		int sent, waited;
		arst_n = 0;
		push = 0;
		pop = 0;
		item = '0;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i]);
		// hold the sender until the parser has drained
		push <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		sent = 0;
		while (sent < 220) begin
			build_message(msg);
			foreach (msg[j]) send_byte(msg[j], j == msg.size() - 1);
			sent += msg.size();
		end
		push <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed && expected_records.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
